FILE: sv/char_lcd_nibble_sequencer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clns assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clns assertion failed");

`endif

FILE: sv/clns_pkg.sv
`timescale 1ns / 1ps

package clns_pkg;

    // Input modes.
    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_CHAR = 2'd1;
    localparam logic [1:0] MODE_INIT = 2'd2;
    localparam logic [1:0] MODE_POS  = 2'd3;

    // Action kinds held by the sequencer.
    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_CHAR,
        KIND_INIT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_action;

    // Pin state steps within one action.
    localparam logic [2:0] STEP_HI_STROBE = 3'd0;
    localparam logic [2:0] STEP_HI_HOLD   = 3'd1;
    localparam logic [2:0] STEP_LO_STROBE = 3'd2;
    localparam logic [2:0] STEP_LO_HOLD   = 3'd3;
    localparam logic [2:0] STEP_RS_DROP   = 3'd4;

    localparam logic [2:0] STEP_LAST_CMD  = STEP_LO_HOLD;
    localparam logic [2:0] STEP_LAST_CHAR = STEP_RS_DROP;
    localparam logic [2:0] STEP_LAST_INIT = 3'd2;

    localparam logic [7:0] GLYPH_BASE = 8'hC0;
    localparam logic [7:0] SET_DDRAM  = 8'h80;

    // Cyrillic code page, indexed by code - GLYPH_BASE.
    localparam logic [7:0] GLYPH_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

endpackage

FILE: sv/clns_decode.sv
`timescale 1ns / 1ps

module clns_decode import clns_pkg::*; (
    input  logic [1:0] i_mode,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_row,
    input  logic [7:0] i_column,
    output t_action    o_action
);

    logic [7:0] glyph;
    logic       row_sel;
    logic [3:0] col_sel;

    always_comb begin
        // remap the upper code block through the glyph table
        if (i_byte_value >= GLYPH_BASE) begin
            glyph = GLYPH_ROM[i_byte_value[5:0]];
        end else begin
            glyph = i_byte_value;
        end
        // clamp row to the second line, wrap wide columns to zero
        row_sel = |i_row;
        col_sel = (i_column[7:4] != 4'd0) ? 4'd0 : i_column[3:0];
    end

    always_comb begin
        case (i_mode)
            MODE_CMD: begin
                o_action.kind = KIND_CMD;
                o_action.code = i_byte_value;
            end
            MODE_CHAR: begin
                o_action.kind = KIND_CHAR;
                o_action.code = glyph;
            end
            MODE_INIT: begin
                o_action.kind = KIND_INIT;
                o_action.code = {4'd0, i_byte_value[3:0]};
            end
            MODE_POS: begin
                o_action.kind = KIND_CMD;
                o_action.code = SET_DDRAM | {1'b0, row_sel, 2'b00, col_sel};
            end
            default: begin
                o_action.kind = KIND_CMD;
                o_action.code = i_byte_value;
            end
        endcase
    end

endmodule

FILE: sv/char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps

// Character LCD nibble sequencer for a 4-bit bus. Each input item (command
// byte, character, init nibble or cursor position) becomes a burst of pin
// states on the result channel, one burst per item: 4 for a command or a
// position, 5 for a character, 3 for an init nibble, the final one flagged
// by o_last. The input register takes a new item every cycle that the
// sequencer is free; the sequencer emits one pin state per cycle, while the
// output is not stalled, through a single output register, and consecutive
// actions follow with no gap. An item goes from the input register through
// the sequencer to the output register.
module char_lcd_nibble_sequencer_core import clns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_row,
    input  logic [7:0] i_column,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_data_nibble,
    output logic       o_reg_select,
    output logic       o_enable,
    output logic       o_last
);

    // input register
    logic       r_a_valid;
    logic [1:0] r_a_mode;
    logic [7:0] r_a_byte;
    logic [7:0] r_a_row;
    logic [7:0] r_a_col;

    // sequencer
    logic       r_b_valid;
    t_action    r_b_act;
    logic [2:0] r_b_step;

    // result register
    logic       r_o_valid;
    logic [3:0] r_o_nibble;
    logic       r_o_rs;
    logic       r_o_en;
    logic       r_o_last;

    t_action    dec_act;
    logic [3:0] n_nibble;
    logic       n_rs;
    logic       n_en;
    logic       n_last;
    logic [2:0] step_last;
    logic       out_load;
    logic       b_emit;
    logic       b_done;
    logic       b_free;
    logic       a_advance;
    logic       in_take;

    clns_decode u_decode (
        .i_mode       (r_a_mode),
        .i_byte_value (r_a_byte),
        .i_row        (r_a_row),
        .i_column     (r_a_col),
        .o_action     (dec_act)
    );

    always_comb begin
        case (r_b_act.kind)
            KIND_INIT: begin
                n_nibble  = r_b_act.code[3:0];
                n_en      = (r_b_step == STEP_HI_STROBE);
                n_rs      = 1'b0;
                step_last = STEP_LAST_INIT;
            end
            KIND_CHAR: begin
                n_nibble  = (r_b_step inside {STEP_HI_STROBE, STEP_HI_HOLD}) ?
                            r_b_act.code[7:4] : r_b_act.code[3:0];
                n_en      = r_b_step inside {STEP_HI_STROBE, STEP_LO_STROBE};
                // drop register select on the trailing state
                n_rs      = (r_b_step != STEP_RS_DROP);
                step_last = STEP_LAST_CHAR;
            end
            default: begin
                n_nibble  = (r_b_step inside {STEP_HI_STROBE, STEP_HI_HOLD}) ?
                            r_b_act.code[7:4] : r_b_act.code[3:0];
                n_en      = r_b_step inside {STEP_HI_STROBE, STEP_LO_STROBE};
                n_rs      = 1'b0;
                step_last = STEP_LAST_CMD;
            end
        endcase
        n_last = (r_b_step == step_last);
    end

    assign out_load   = !r_o_valid || i_out_ready;
    assign b_emit     = r_b_valid && out_load;
    assign b_done     = b_emit && n_last;
    assign b_free     = !r_b_valid || b_done;
    assign a_advance  = r_a_valid && b_free;
    assign o_in_ready = !r_a_valid || a_advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_step  <= STEP_HI_STROBE;
            r_o_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
                r_b_step  <= STEP_HI_STROBE;
            end else if (b_emit) begin
                r_b_step <= r_b_step + 3'd1;
            end
            if (out_load) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_mode <= i_mode;
            r_a_byte <= i_byte_value;
            r_a_row  <= i_row;
            r_a_col  <= i_column;
        end
        if (a_advance) begin
            r_b_act <= dec_act;
        end
        if (b_emit) begin
            r_o_nibble <= n_nibble;
            r_o_rs     <= n_rs;
            r_o_en     <= n_en;
            r_o_last   <= n_last;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_data_nibble = r_o_nibble;
    assign o_reg_select  = r_o_rs;
    assign o_enable      = r_o_en;
    assign o_last        = r_o_last;

endmodule

FILE: sv/clns_checker.sv
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_core_assert.svh"

module clns_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_mode,
    input logic [7:0] i_byte_value,
    input logic [7:0] i_row,
    input logic [7:0] i_column,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_data_nibble,
    input logic       o_reg_select,
    input logic       o_enable,
    input logic       o_last
);

    // hold a stalled input item
    `CLNS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready,
        i_in_valid && $stable(i_mode) && $stable(i_byte_value) && $stable(i_row)
        && $stable(i_column))

    // hold a stalled pin state
    `CLNS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_data_nibble) && $stable(o_reg_select)
        && $stable(o_enable) && $stable(o_last))

    // a strobe never closes an action
    `CLNS_ASSERT_SAME(a_strobe_not_last, i_clk, i_rst_n, o_out_valid && o_enable, !o_last)

    // every action ends with register select low
    `CLNS_ASSERT_SAME(a_last_rs_low, i_clk, i_rst_n, o_out_valid && o_last, !o_reg_select)

    // a strobe is followed at once by the falling edge on the same nibble
    `CLNS_ASSERT_NEXT(a_strobe_fall, i_clk, i_rst_n, o_out_valid && i_out_ready && o_enable,
        o_out_valid && !o_enable && (o_data_nibble == $past(o_data_nibble)))

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (.*);

FILE: sim/char_lcd_nibble_sequencer_core_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core_tb import clns_pkg::*;;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_ITEMS = 262;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_AFTER   = 60;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [7:0]  ROW1_OFFSET  = 8'h40;
    localparam logic [7:0]  LAST_COLUMN  = 8'd15;

    // Cyrillic code page, indexed by the low six bits of a code at or above GLYPH_BASE.
    localparam logic [7:0] CYR_GLYPHS [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic [7:0] row;
        logic [7:0] column;
    } t_lcd_req;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic       en;
        logic       last;
    } t_pin_state;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_mode       = '0;
    logic [7:0] i_byte_value = '0;
    logic [7:0] i_row        = '0;
    logic [7:0] i_column     = '0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [3:0] o_data_nibble;
    logic       o_reg_select;
    logic       o_enable;
    logic       o_last;

    t_lcd_req   req_backlog[$];
    t_pin_state pin_states_due[$];
    int         reqs_total   = 0;
    int         reqs_taken   = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;
    int         burst_left   = 0;
    int         gap_left     = 0;
    int         hold_left    = 0;
    logic       hold_done    = 1'b0;

    char_lcd_nibble_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_byte_value  (i_byte_value),
        .i_row         (i_row),
        .i_column      (i_column),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_nibble (o_data_nibble),
        .o_reg_select  (o_reg_select),
        .o_enable      (o_enable),
        .o_last        (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void add_req(logic [1:0] mode, logic [7:0] b, logic [7:0] r,
                                    logic [7:0] c);
        t_lcd_req req;
        req.mode       = mode;
        req.byte_value = b;
        req.row        = r;
        req.column     = c;
        req_backlog.push_back(req);
        reqs_total++;
    endfunction

    function automatic void push_pin(logic [3:0] nib, logic rs, logic en, logic last);
        t_pin_state ps;
        ps.nibble = nib;
        ps.rs     = rs;
        ps.en     = en;
        ps.last   = last;
        pin_states_due.push_back(ps);
    endfunction

    function automatic void push_command(logic [7:0] b);
        push_pin(b[7:4], 1'b0, 1'b1, 1'b0);
        push_pin(b[7:4], 1'b0, 1'b0, 1'b0);
        push_pin(b[3:0], 1'b0, 1'b1, 1'b0);
        push_pin(b[3:0], 1'b0, 1'b0, 1'b1);
    endfunction

    // Expand one action into the pin states it drives on the bus.
    function automatic void predict_pin_states(t_lcd_req req);
        logic [7:0] glyph;
        logic [7:0] line;
        logic [7:0] col;
        case (req.mode)
            MODE_CMD: begin
                push_command(req.byte_value);
            end
            MODE_CHAR: begin
                glyph = req.byte_value;
                if (glyph >= GLYPH_BASE) glyph = CYR_GLYPHS[glyph[5:0]];
                push_pin(glyph[7:4], 1'b1, 1'b1, 1'b0);
                push_pin(glyph[7:4], 1'b1, 1'b0, 1'b0);
                push_pin(glyph[3:0], 1'b1, 1'b1, 1'b0);
                push_pin(glyph[3:0], 1'b1, 1'b0, 1'b0);
                push_pin(glyph[3:0], 1'b0, 1'b0, 1'b1);
            end
            MODE_INIT: begin
                push_pin(req.byte_value[3:0], 1'b0, 1'b1, 1'b0);
                push_pin(req.byte_value[3:0], 1'b0, 1'b0, 1'b0);
                push_pin(req.byte_value[3:0], 1'b0, 1'b0, 1'b1);
            end
            default: begin
                line = (req.row > 8'd1) ? 8'd1 : req.row;
                col  = (req.column > LAST_COLUMN) ? 8'd0 : req.column;
                push_command(SET_DDRAM + col + (line[0] ? ROW1_OFFSET : 8'd0));
            end
        endcase
    endfunction

    // Driver: bursts of items with random gaps between them.
    always @(posedge i_clk) begin : request_driver
        t_lcd_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                req.mode       = i_mode;
                req.byte_value = i_byte_value;
                req.row        = i_row;
                req.column     = i_column;
                predict_pin_states(req);
                reqs_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    req = req_backlog.pop_front();
                    i_mode       <= req.mode;
                    i_byte_value <= req.byte_value;
                    i_row        <= req.row;
                    i_column     <= req.column;
                    i_in_valid   <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side so the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each pin state against the oldest prediction.
    always @(posedge i_clk) begin : pin_monitor
        t_pin_state want;
        logic       ready_next;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pin_states_due.size() == 0) begin
                $error("pin state with none predicted: nibble %0h rs %0b en %0b last %0b",
                       o_data_nibble, o_reg_select, o_enable, o_last);
                fail_count++;
            end else begin
                want = pin_states_due.pop_front();
                if (o_data_nibble !== want.nibble) begin
                    $error("data_nibble expected %0h got %0h", want.nibble, o_data_nibble);
                    fail_count++;
                end
                if (o_reg_select !== want.rs) begin
                    $error("reg_select expected %0b got %0b", want.rs, o_reg_select);
                    fail_count++;
                end
                if (o_enable !== want.en) begin
                    $error("enable expected %0b got %0b", want.en, o_enable);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, o_last);
                    fail_count++;
                end
            end
        end
        // Stall pattern steps through four phases, chosen by bits 7:6 of cycle_count: open, light, periodic, heavy.
        case (cycle_count[7:6])
            2'd0:    ready_next = 1'b1;
            2'd1:    ready_next = ($urandom_range(0, 99) < 75);
            2'd2:    ready_next = (cycle_count % 3 != 0);
            default: ready_next = ($urandom_range(0, 99) < 30);
        endcase
        i_out_ready <= ready_next && (hold_left == 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [1:0] mode;
        logic [7:0] b;
        logic [7:0] r;
        logic [7:0] c;

        // Byte extremes, garbage in unused fields.
        add_req(MODE_CMD, 8'h00, 8'hFF, 8'hFF);
        add_req(MODE_CMD, 8'hFF, 8'h00, 8'h00);
        add_req(MODE_CMD, 8'hA5, 8'h5A, 8'hC3);
        // Plain characters, then the Cyrillic range ends and middle.
        add_req(MODE_CHAR, 8'h00, 8'hFF, 8'hFF);
        add_req(MODE_CHAR, 8'h41, 8'h00, 8'h00);
        add_req(MODE_CHAR, 8'hBF, 8'h00, 8'h00);
        add_req(MODE_CHAR, 8'hC0, 8'h00, 8'h00);
        add_req(MODE_CHAR, 8'hDF, 8'h00, 8'h00);
        add_req(MODE_CHAR, 8'hFF, 8'h00, 8'h00);
        // Init nibble: high bits of the byte are ignored.
        add_req(MODE_INIT, 8'h03, 8'h00, 8'h00);
        add_req(MODE_INIT, 8'hF2, 8'hFF, 8'hFF);
        add_req(MODE_INIT, 8'h0F, 8'h00, 8'h00);
        add_req(MODE_INIT, 8'hF0, 8'h00, 8'h00);
        // Set position: in range, clamped row, wrapped column.
        add_req(MODE_POS, 8'hFF, 8'h00, 8'h00);
        add_req(MODE_POS, 8'h00, 8'h01, 8'h0F);
        add_req(MODE_POS, 8'h00, 8'h02, 8'h10);
        add_req(MODE_POS, 8'hFF, 8'hFF, 8'hFF);
        add_req(MODE_POS, 8'h00, 8'h80, 8'h07);

        repeat (RANDOM_ITEMS) begin
            mode = 2'($urandom_range(0, 3));
            b    = 8'($urandom_range(0, 255));
            r    = 8'($urandom_range(0, 255));
            c    = 8'($urandom_range(0, 255));
            if (mode == MODE_CHAR && $urandom_range(0, 1) == 1)
                b = 8'($urandom_range(GLYPH_BASE, 255));
            if (mode == MODE_POS && $urandom_range(0, 3) != 0) begin
                r = 8'($urandom_range(0, 2));
                c = 8'($urandom_range(0, 17));
            end
            add_req(mode, b, r, c);
        end

        wait (reqs_taken == reqs_total);
        wait (pin_states_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
